### src/cfht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfht_pkg
// Shared constants and types for the homographic continued fraction block.
// ----------------------------------------------------------------------------
package cfht_pkg;

    localparam int unsigned COEF_W   = 64;
    localparam int unsigned PROD_W   = 2 * COEF_W;
    localparam int unsigned MAX_EMIT = 64;
    localparam int unsigned CNT_W    = $clog2(MAX_EMIT + 1);
    localparam int unsigned STEP_W   = $clog2(COEF_W);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COEF_W - 1);
    localparam logic [CNT_W-1:0]  EMIT_CAP  = CNT_W'(MAX_EMIT);
    localparam logic [CNT_W-1:0]  FLUSH_CAP = CNT_W'(MAX_EMIT - 1);

    localparam logic [COEF_W-1:0] COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [COEF_W-1:0] COEF_M1    = {COEF_W{1'b1}};
    localparam logic [COEF_W-1:0] INIT_A_RST = COEF_W'(1);
    localparam logic [COEF_W-1:0] INIT_B_RST = '0;
    localparam logic [COEF_W-1:0] INIT_C_RST = '0;
    localparam logic [COEF_W-1:0] INIT_D_RST = COEF_W'(1);

    // configuration register indexes
    localparam logic [1:0] REG_INIT_A = 2'd0;
    localparam logic [1:0] REG_INIT_B = 2'd1;
    localparam logic [1:0] REG_INIT_C = 2'd2;
    localparam logic [1:0] REG_INIT_D = 2'd3;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_MUL    = 12'b0000_0000_0010,
        S_MNEG   = 12'b0000_0000_0100,
        S_MADD   = 12'b0000_0000_1000,
        S_LOOP   = 12'b0000_0001_0000,
        S_FLOOP  = 12'b0000_0010_0000,
        S_DIV    = 12'b0000_0100_0000,
        S_DFIX1  = 12'b0000_1000_0000,
        S_DFIX2  = 12'b0001_0000_0000,
        S_DECIDE = 12'b0010_0000_0000,
        S_EMIT   = 12'b0100_0000_0000,
        S_FINISH = 12'b1000_0000_0000
    } t_state;

endpackage

### src/continued_fraction_homographic_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// continued_fraction_homographic_transform
// Mobius map (a*x+b)/(c*x+d) applied to a streamed continued fraction.
// ----------------------------------------------------------------------------
// Usage:
// - input stream: tdata carries the next term, tuser flags end of input.
//   The block takes one transfer, then drops s_axis_tready until every
//   result of that item has been handed to the output register.
// - output stream: tdata is the emitted term, tuser holds done and overflow,
//   tlast marks the last result of the current input item. An item that
//   yields nothing gives no transfer at all.
// - a term is absorbed by two 64-step shift-add multiplies; each emitted
//   term costs two 64-step restoring divides plus fix-up, a flush step one
//   divide. The multiplier and divider are shared.
// - one result is staged before the output register so tlast is known; a
//   stalled receiver holds the block in the emit or finish step, nothing is lost.
// - reset (synchronous, active low) loads init registers 1, 0, 0, 1 into
//   the coefficients; config writes only change the init registers, which
//   are reloaded after a completed flush or an aborted run.
// ----------------------------------------------------------------------------
module continued_fraction_homographic_transform
    import cfht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_addr,
    input  logic [COEF_W-1:0] i_cfg_wdata,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [COEF_W-1:0] s_axis_tdata,   // [63:0] term_in
    input  logic              s_axis_tuser,   // [0] input_ended
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [COEF_W-1:0] m_axis_tdata,   // [63:0] term_out
    output logic [1:0]        m_axis_tuser,   // [0] fraction_done, [1] overflow
    output logic              m_axis_tlast    // last
);

    t_state r_state;

    logic [COEF_W-1:0] r_init_a, r_init_b, r_init_c, r_init_d;
    logic [COEF_W-1:0] r_a, r_b, r_c, r_d;
    logic [COEF_W-1:0] r_p;
    logic              r_ended;
    logic [CNT_W-1:0]  r_n;

    // shared multiplier
    logic [COEF_W-1:0] r_mc, r_mz, r_na;
    logic [PROD_W-1:0] r_acc;
    logic              r_msgn, r_phase, r_bad;
    logic [STEP_W-1:0] r_step;

    // shared divider
    logic [COEF_W-1:0] r_quo, r_rem, r_dd, r_dv, r_qt, r_rt;
    logic              r_sn, r_sd;
    logic [COEF_W-1:0] r_q1, r_r1, r_q0, r_r0;

    // result staging
    logic [COEF_W-1:0] r_new_term, r_pend_term, r_out_term;
    logic              r_new_done, r_new_ovf, r_new_final;
    logic              r_pend_valid, r_pend_done, r_pend_ovf;
    logic              r_out_valid, r_out_done, r_out_ovf, r_out_last;

    logic              in_xfer, out_free, out_load;
    logic [COEF_W:0]   mul_sum;
    logic [COEF_W:0]   div_trial;
    logic [PROD_W-1:0] madd_sum;
    logic              madd_bad;
    logic              ok1, ok0;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    // staged result moves into the output register this cycle
    assign out_load = r_pend_valid && out_free &&
                      (r_state == S_EMIT || r_state == S_FINISH);

    // one shift-add step and one restoring divide step
    assign mul_sum   = {1'b0, r_acc[PROD_W-1:COEF_W]} + (r_acc[0] ? {1'b0, r_mc} : '0);
    assign div_trial = {r_rem, r_quo[COEF_W-1]} - {1'b0, r_dd};
    assign madd_sum  = r_acc + {{COEF_W{r_mz[COEF_W-1]}}, r_mz};
    assign madd_bad  = !((&madd_sum[PROD_W-1:COEF_W-1]) || !(|madd_sum[PROD_W-1:COEF_W-1]));

    // quotient 2^63 cannot be represented
    assign ok1 = !(r_a == COEF_MIN && r_c == COEF_M1);
    assign ok0 = !(r_b == COEF_MIN && r_d == COEF_M1);

    // main sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_init_a     <= INIT_A_RST;
            r_init_b     <= INIT_B_RST;
            r_init_c     <= INIT_C_RST;
            r_init_d     <= INIT_D_RST;
            r_a          <= INIT_A_RST;
            r_b          <= INIT_B_RST;
            r_c          <= INIT_C_RST;
            r_d          <= INIT_D_RST;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_n          <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    REG_INIT_A: r_init_a <= i_cfg_wdata;
                    REG_INIT_B: r_init_b <= i_cfg_wdata;
                    REG_INIT_C: r_init_c <= i_cfg_wdata;
                    REG_INIT_D: r_init_d <= i_cfg_wdata;
                    default:    r_init_a <= r_init_a;
                endcase
            end

            if (r_out_valid && m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_ended <= s_axis_tuser;
                        r_n     <= '0;
                        if (s_axis_tuser) begin
                            r_b     <= r_a;
                            r_d     <= r_c;
                            r_state <= S_FLOOP;
                        end else begin
                            r_p     <= s_axis_tdata;
                            r_phase <= 1'b0;
                            r_mc    <= r_a[COEF_W-1] ? -r_a : r_a;
                            r_acc   <= {{COEF_W{1'b0}},
                                        s_axis_tdata[COEF_W-1] ? -s_axis_tdata : s_axis_tdata};
                            r_msgn  <= r_a[COEF_W-1] ^ s_axis_tdata[COEF_W-1];
                            r_mz    <= r_b;
                            r_step  <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end

                // magnitude product, one multiplier bit a cycle
                S_MUL: begin
                    r_acc  <= {mul_sum, r_acc[COEF_W-1:1]};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_LAST) begin
                        r_state <= S_MNEG;
                    end
                end

                S_MNEG: begin
                    r_acc   <= r_msgn ? -r_acc : r_acc;
                    r_state <= S_MADD;
                end

                // add constant term and check the range
                S_MADD: begin
                    if (!r_phase) begin
                        r_na    <= madd_sum[COEF_W-1:0];
                        r_bad   <= madd_bad;
                        r_phase <= 1'b1;
                        r_mc    <= r_c[COEF_W-1] ? -r_c : r_c;
                        r_acc   <= {{COEF_W{1'b0}}, r_p[COEF_W-1] ? -r_p : r_p};
                        r_msgn  <= r_c[COEF_W-1] ^ r_p[COEF_W-1];
                        r_mz    <= r_d;
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end else if (r_bad || madd_bad) begin
                        r_new_term  <= '0;
                        r_new_done  <= 1'b1;
                        r_new_ovf   <= 1'b1;
                        r_new_final <= 1'b1;
                        r_a <= r_init_a; r_b <= r_init_b;
                        r_c <= r_init_c; r_d <= r_init_d;
                        r_state <= S_EMIT;
                    end else begin
                        r_a <= r_na;
                        r_b <= r_a;
                        r_c <= madd_sum[COEF_W-1:0];
                        r_d <= r_c;
                        r_state <= S_LOOP;
                    end
                end

                // streaming emission check
                S_LOOP: begin
                    if (r_n == EMIT_CAP || r_c == '0 || r_d == '0) begin
                        r_state <= S_FINISH;
                    end else if (!ok1 && !ok0) begin
                        r_new_term  <= '0;
                        r_new_done  <= 1'b1;
                        r_new_ovf   <= 1'b1;
                        r_new_final <= 1'b1;
                        r_a <= r_init_a; r_b <= r_init_b;
                        r_c <= r_init_c; r_d <= r_init_d;
                        r_state <= S_EMIT;
                    end else if (!ok1 || !ok0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_phase <= 1'b0;
                        r_quo   <= r_a[COEF_W-1] ? -r_a : r_a;
                        r_dd    <= r_c[COEF_W-1] ? -r_c : r_c;
                        r_dv    <= r_c;
                        r_sn    <= r_a[COEF_W-1];
                        r_sd    <= r_c[COEF_W-1];
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end

                // flush emission check
                S_FLOOP: begin
                    if (r_c == '0) begin
                        r_new_term  <= '0;
                        r_new_done  <= 1'b1;
                        r_new_ovf   <= 1'b0;
                        r_new_final <= 1'b1;
                        r_a <= r_init_a; r_b <= r_init_b;
                        r_c <= r_init_c; r_d <= r_init_d;
                        r_state <= S_EMIT;
                    end else if (r_n >= FLUSH_CAP || !ok1) begin
                        r_new_term  <= '0;
                        r_new_done  <= 1'b1;
                        r_new_ovf   <= 1'b1;
                        r_new_final <= 1'b1;
                        r_a <= r_init_a; r_b <= r_init_b;
                        r_c <= r_init_c; r_d <= r_init_d;
                        r_state <= S_EMIT;
                    end else begin
                        r_phase <= 1'b0;
                        r_quo   <= r_a[COEF_W-1] ? -r_a : r_a;
                        r_dd    <= r_c[COEF_W-1] ? -r_c : r_c;
                        r_dv    <= r_c;
                        r_sn    <= r_a[COEF_W-1];
                        r_sd    <= r_c[COEF_W-1];
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end

                // restoring divide, one quotient bit a cycle
                S_DIV: begin
                    if (!div_trial[COEF_W]) begin
                        r_rem <= div_trial[COEF_W-1:0];
                        r_quo <= {r_quo[COEF_W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[COEF_W-2:0], r_quo[COEF_W-1]};
                        r_quo <= {r_quo[COEF_W-2:0], 1'b0};
                    end
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_LAST) begin
                        r_state <= S_DFIX1;
                    end
                end

                // apply signs of the truncating result
                S_DFIX1: begin
                    r_qt    <= (r_sn ^ r_sd) ? -r_quo : r_quo;
                    r_rt    <= r_sn ? -r_rem : r_rem;
                    r_state <= S_DFIX2;
                end

                // round toward minus infinity
                S_DFIX2: begin
                    if (r_rt != '0 && (r_rt[COEF_W-1] != r_sd)) begin
                        if (!r_phase) begin
                            r_q1 <= r_qt - COEF_W'(1); r_r1 <= r_rt + r_dv;
                        end else begin
                            r_q0 <= r_qt - COEF_W'(1); r_r0 <= r_rt + r_dv;
                        end
                    end else begin
                        if (!r_phase) begin
                            r_q1 <= r_qt; r_r1 <= r_rt;
                        end else begin
                            r_q0 <= r_qt; r_r0 <= r_rt;
                        end
                    end
                    if (!r_ended && !r_phase) begin
                        r_phase <= 1'b1;
                        r_quo   <= r_b[COEF_W-1] ? -r_b : r_b;
                        r_dd    <= r_d[COEF_W-1] ? -r_d : r_d;
                        r_dv    <= r_d;
                        r_sn    <= r_b[COEF_W-1];
                        r_sd    <= r_d[COEF_W-1];
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_DECIDE;
                    end
                end

                // emit the quotient when both bounds agree or input has ended, and reduce the matrix
                S_DECIDE: begin
                    if (r_ended) begin
                        r_new_term  <= r_q1;
                        r_new_done  <= 1'b0;
                        r_new_ovf   <= 1'b0;
                        r_new_final <= 1'b0;
                        r_a <= r_c; r_b <= r_c;
                        r_c <= r_r1; r_d <= r_r1;
                        r_n <= r_n + CNT_W'(1);
                        r_state <= S_EMIT;
                    end else if (r_q1 != r_q0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_new_term  <= r_q1;
                        r_new_done  <= 1'b0;
                        r_new_ovf   <= 1'b0;
                        r_new_final <= 1'b0;
                        r_a <= r_c; r_b <= r_d;
                        r_c <= r_r1; r_d <= r_r0;
                        r_n <= r_n + CNT_W'(1);
                        r_state <= S_EMIT;
                    end
                end

                // stage the new result, push the older one out
                S_EMIT: begin
                    if (!r_pend_valid || out_free) begin
                        if (r_pend_valid) begin
                            r_out_valid <= 1'b1;
                            r_out_term  <= r_pend_term;
                            r_out_done  <= r_pend_done;
                            r_out_ovf   <= r_pend_ovf;
                            r_out_last  <= 1'b0;
                        end
                        r_pend_valid <= 1'b1;
                        r_pend_term  <= r_new_term;
                        r_pend_done  <= r_new_done;
                        r_pend_ovf   <= r_new_ovf;
                        if (r_new_final) begin
                            r_state <= S_FINISH;
                        end else if (r_ended) begin
                            r_state <= S_FLOOP;
                        end else begin
                            r_state <= S_LOOP;
                        end
                    end
                end

                // hand over the staged result as the last one
                S_FINISH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_term   <= r_pend_term;
                        r_out_done   <= r_pend_done;
                        r_out_ovf    <= r_pend_ovf;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_term;
    assign m_axis_tuser  = {r_out_ovf, r_out_done};
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTH
    // no staged result may be left behind when a new item can enter
    a_idle_pend_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_pend_valid)
        else $error("staged result left while idle");

    // the emission count never passes the cap
    a_emit_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= EMIT_CAP)
        else $error("emission count beyond cap");

    // a done result carries a zero term and is marked last
    a_done_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> (r_out_term == '0 && r_out_last))
        else $error("done result with term or without last");
`endif

endmodule

### tb/sv/tb_continued_fraction_homographic_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_continued_fraction_homographic_transform
// Streams continued fraction terms through the homographic transform, checks
// every output transfer against a cycle-free model of the coefficient matrix,
// and switches the initial coefficients between phases.
// ----------------------------------------------------------------------------
module tb_continued_fraction_homographic_transform;
    import cfht_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 400;

    typedef struct packed {
        logic signed [63:0] term;
        logic               done;
        logic               ovf;
        logic               lst;
    } t_result;

    typedef struct {
        logic signed [63:0] term;
        logic               ended;
        logic               has_exp;
        t_result            exp_res;
    } t_stim;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [1:0] i_cfg_addr = REG_INIT_A;
    logic [COEF_W-1:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [COEF_W-1:0] s_axis_tdata = '0;   // [63:0] term_in
    logic s_axis_tuser = 1'b0;              // [0] input_ended
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [COEF_W-1:0] m_axis_tdata;        // [63:0] term_out
    logic [1:0] m_axis_tuser;               // [0] fraction_done, [1] overflow
    logic m_axis_tlast;

    continued_fraction_homographic_transform i_dut (.*);

    always #5 i_clk = ~i_clk;

    // model state
    logic signed [63:0] init_q [4];
    logic signed [63:0] ca, cb, cc, cd;
    t_result pending_results [$];
    int n_pushed = 0;
    int errors = 0;
    int idle_cycles = 0;

    function automatic logic signed [63:0] fold_mul_add(input logic signed [63:0] x,
            input logic signed [63:0] y, input logic signed [63:0] z, inout bit bad);
        logic signed [129:0] full;
        full = $signed(x) * $signed(y) + $signed(z);
        if (full > 130'sh7FFFFFFFFFFFFFFF || full < -130'sh8000000000000000) bad = 1'b1;
        return full[63:0];
    endfunction

    // floor division; returns 0 when the quotient is 2^63
    function automatic bit floor_quot(input logic signed [63:0] n,
            input logic signed [63:0] dv, output logic signed [63:0] q,
            output logic signed [63:0] r);
        q = 0;
        r = 0;
        if (n == $signed(COEF_MIN) && dv == -64'sd1) return 1'b0;
        q = n / dv;
        r = n % dv;
        if (r != 0 && ((r < 0) != (dv < 0))) begin
            q = q - 1;
            r = r + dv;
        end
        return 1'b1;
    endfunction

    function automatic void reload_coefs();
        ca = init_q[0]; cb = init_q[1]; cc = init_q[2]; cd = init_q[3];
    endfunction

    // compute results of one accepted item and queue them
    function automatic void transform_item(input logic signed [63:0] p, input logic ended);
        t_result outs [$];
        logic signed [63:0] q1, r1, q0, r0, na, nc;
        bit bad, ok1, ok0;
        bad = 1'b0;
        if (ended) begin
            cb = ca;
            cd = cc;
            forever begin
                if (cc == 0) begin
                    outs.push_back('{0, 1'b1, 1'b0, 1'b0});
                    reload_coefs();
                    break;
                end
                if (outs.size() >= MAX_EMIT - 1 || !floor_quot(ca, cc, q1, r1)) begin
                    outs.push_back('{0, 1'b1, 1'b1, 1'b0});
                    reload_coefs();
                    break;
                end
                outs.push_back('{q1, 1'b0, 1'b0, 1'b0});
                ca = cc; cc = r1; cb = ca; cd = cc;
            end
        end else begin
            na = fold_mul_add(ca, p, cb, bad);
            nc = fold_mul_add(cc, p, cd, bad);
            if (bad) begin
                outs.push_back('{0, 1'b1, 1'b1, 1'b0});
                reload_coefs();
            end else begin
                cb = ca; ca = na; cd = cc; cc = nc;
                while (outs.size() < MAX_EMIT && cc != 0 && cd != 0) begin
                    ok1 = floor_quot(ca, cc, q1, r1);
                    ok0 = floor_quot(cb, cd, q0, r0);
                    if (!ok1 && !ok0) begin
                        outs.push_back('{0, 1'b1, 1'b1, 1'b0});
                        reload_coefs();
                        break;
                    end
                    if (!ok1 || !ok0 || q1 != q0) break;
                    outs.push_back('{q1, 1'b0, 1'b0, 1'b0});
                    ca = cc; cb = cd; cc = r1; cd = r0;
                end
            end
        end
        if (outs.size() > 0) outs[outs.size()-1].lst = 1'b1;
        n_pushed += outs.size();
        foreach (outs[k]) pending_results.push_back(outs[k]);
    endfunction

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // output side: random backpressure, compare each transfer
    int ready_gap = 0;
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{$signed(m_axis_tdata), m_axis_tuser[0], m_axis_tuser[1],
                        m_axis_tlast};
                if (pending_results.size() == 0) begin
                    $error("unexpected result term %0d", got.term);
                    errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got.term !== exp_r.term) begin
                        $error("term_out exp %0d got %0d", exp_r.term, got.term);
                        errors++;
                    end
                    if (got.done !== exp_r.done) begin
                        $error("fraction_done exp %0b got %0b", exp_r.done, got.done);
                        errors++;
                    end
                    if (got.ovf !== exp_r.ovf) begin
                        $error("overflow exp %0b got %0b", exp_r.ovf, got.ovf);
                        errors++;
                    end
                    if (got.lst !== exp_r.lst) begin
                        $error("last exp %0b got %0b", exp_r.lst, got.lst);
                        errors++;
                    end
                end
            end
            if (ready_gap > 0) begin
                ready_gap <= ready_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tready && m_axis_tvalid && $urandom_range(0, 3) == 0) begin
                ready_gap <= gap_len();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one register write; the caller drops the enable after its last write
    task automatic write_init(input logic [1:0] idx, input logic signed [63:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        init_q[idx] = val;
        @(posedge i_clk);
    endtask

    // one input transfer, optional random gap before it
    task automatic send_term(input logic signed [63:0] p, input logic ended, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        s_axis_tuser  <= ended;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        transform_item(p, ended);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [63:0] rand_term();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) return $urandom_range(1, 12);
        if (sel < 16) return -$signed(64'($urandom_range(1, 12)));
        if (sel < 17) return 0;
        return $signed({$urandom(), $urandom()});
    endfunction

    t_stim directed [$];
    t_result chk;

    initial begin
        int n_before;
        init_q[0] = 1; init_q[1] = 0; init_q[2] = 0; init_q[3] = 1;
        reload_coefs();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: identity map, extremes, overflow
        directed.push_back('{0, 1'b1, 1'b1, '{0, 1'b1, 1'b0, 1'b1}});   // flush at reset: c=0
        directed.push_back('{3, 1'b0, 1'b0, '{0, 0, 0, 0}});
        directed.push_back('{7, 1'b0, 1'b0, '{0, 0, 0, 0}});
        directed.push_back('{15, 1'b0, 1'b0, '{0, 0, 0, 0}});
        directed.push_back('{0, 1'b1, 1'b0, '{0, 0, 0, 0}});
        directed.push_back('{64'sh7FFFFFFFFFFFFFFF, 1'b0, 1'b0, '{0, 0, 0, 0}});
        directed.push_back('{2, 1'b0, 1'b1, '{0, 1'b1, 1'b1, 1'b1}});  // absorb overflow
        directed.push_back('{$signed(COEF_MIN), 1'b0, 1'b0, '{0, 0, 0, 0}});
        directed.push_back('{-1, 1'b0, 1'b1, '{0, 1'b1, 1'b1, 1'b1}});
        directed.push_back('{-5, 1'b0, 1'b0, '{0, 0, 0, 0}});
        directed.push_back('{0, 1'b0, 1'b0, '{0, 0, 0, 0}});
        directed.push_back('{1, 1'b0, 1'b0, '{0, 0, 0, 0}});
        directed.push_back('{0, 1'b1, 1'b0, '{0, 0, 0, 0}});
        foreach (directed[k]) begin
            n_before = n_pushed;
            send_term(directed[k].term, directed[k].ended, 0);
            if (directed[k].has_exp) begin
                chk = pending_results[pending_results.size()-1];
                if (n_pushed != n_before + 1 || chk !== directed[k].exp_res) begin
                    $error("directed row %0d: table entry disagrees with model", k);
                    errors++;
                end
            end
        end
        wait_idle();

        // phase settings: a plain map, extremes of the init registers, then random maps
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_init(REG_INIT_A, 2); write_init(REG_INIT_B, 1);
                    write_init(REG_INIT_C, 0); write_init(REG_INIT_D, 1);
                end
                1: begin
                    write_init(REG_INIT_A, $signed(COEF_MIN));
                    write_init(REG_INIT_B, 64'sh7FFFFFFFFFFFFFFF);
                    write_init(REG_INIT_C, -1);
                    write_init(REG_INIT_D, $signed(COEF_MIN));
                end
                2: begin
                    write_init(REG_INIT_A, 64'sh7FFFFFFFFFFFFFFF);
                    write_init(REG_INIT_B, 0);
                    write_init(REG_INIT_C, 0);
                    write_init(REG_INIT_D, -1);
                end
                default: begin
                    write_init(REG_INIT_A, $signed(64'($urandom_range(0, 9))) - 4);
                    write_init(REG_INIT_B, $signed(64'($urandom_range(0, 9))) - 4);
                    write_init(REG_INIT_C, $signed(64'($urandom_range(0, 9))) - 4);
                    write_init(REG_INIT_D, $signed(64'($urandom_range(1, 9))));
                end
            endcase
            i_cfg_wr_en <= 1'b0;
            // the initial values only apply after a reload, so force one
            send_term(0, 1'b1, 0);
            for (int k = 0; k < 26; k++) begin
                if ($urandom_range(0, 7) == 0)
                    send_term(rand_term(), 1'b1, gap_len());
                else
                    send_term(rand_term(), 1'b0, ($urandom_range(0, 2) == 0) ? 0 : gap_len());
                if (k == 15) begin
                    // sender holds off until every result has arrived
                    s_axis_tvalid <= 1'b0;
                    do @(posedge i_clk); while (pending_results.size() != 0);
                end
            end
            send_term(0, 1'b1, 0);
            wait_idle();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
src/cfht_pkg.sv
src/continued_fraction_homographic_transform.sv
tb/sv/tb_continued_fraction_homographic_transform.sv
